FILE: hw/rtl/crtc_pkg.sv
package crtc_pkg;

    // Access kinds carried in the input tuser field
    typedef enum logic [1:0] {
        ACT_SELECT = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_READ   = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    localparam int unsigned REG_IDX_W   = 5;
    localparam int unsigned POS_W       = 13;
    localparam int unsigned ADDR_W      = 14;
    localparam int unsigned CHAR_W_W    = 5;
    localparam int unsigned FRAME_CNT_W = 5;

    localparam logic [CHAR_W_W-1:0] CHAR_WIDTH_RESET = 5'd8;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_H_TOTAL      = 5'd0;
    localparam logic [REG_IDX_W-1:0] REG_V_TOTAL      = 5'd4;
    localparam logic [REG_IDX_W-1:0] REG_V_ADJUST     = 5'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SCAN     = 5'd9;
    localparam logic [REG_IDX_W-1:0] REG_CURSOR_START = 5'd10;
    localparam logic [REG_IDX_W-1:0] REG_CURSOR_END   = 5'd11;
    localparam logic [REG_IDX_W-1:0] REG_START_HI     = 5'd12;
    localparam logic [REG_IDX_W-1:0] REG_START_LO     = 5'd13;
    localparam logic [REG_IDX_W-1:0] REG_CURSOR_HI    = 5'd14;
    localparam logic [REG_IDX_W-1:0] REG_CURSOR_LO    = 5'd15;
    localparam logic [REG_IDX_W-1:0] REG_LAST         = 5'd17;
    localparam logic [REG_IDX_W-1:0] REG_INVALID      = 5'd31;

    localparam logic [7:0] READ_NONE = 8'hFF;

    // Timing registers consumed by the raster counters
    typedef struct packed {
        logic [7:0] h_total_chars;
        logic [6:0] v_total_rows;
        logic [4:0] v_adjust_lines;
        logic [4:0] max_scan_line;
    } t_timing;

    // Address and cursor registers shown with every result
    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] cursor_addr;
        logic [6:0]        cursor_start;
        logic [4:0]        cursor_end;
    } t_disp;

    // Raster status after one step
    typedef struct packed {
        logic             row_end;
        logic             frame_end;
        logic             blink_fast;
        logic             blink_slow;
        logic [POS_W-1:0] h_pos;
        logic [POS_W-1:0] v_pos;
    } t_raster;

endpackage

FILE: hw/rtl/crtc_regs.sv
module crtc_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  crtc_pkg::t_action   i_action,
    input  logic [7:0]          i_data,
    output crtc_pkg::t_timing   o_timing,
    output crtc_pkg::t_disp     o_disp,
    output logic [7:0]          o_read_data
);

    // Only registers that feed an output or the raster are stored; writes to
    // the display, sync and interlace registers are accepted and dropped.
    logic [crtc_pkg::REG_IDX_W-1:0] r_sel,         n_sel;
    logic [7:0]                     r_h_total,     n_h_total;
    logic [6:0]                     r_v_total,     n_v_total;
    logic [4:0]                     r_v_adjust,    n_v_adjust;
    logic [4:0]                     r_max_scan,    n_max_scan;
    logic [6:0]                     r_cur_start,   n_cur_start;
    logic [4:0]                     r_cur_end,     n_cur_end;
    logic [crtc_pkg::ADDR_W-1:0]    r_start_addr,  n_start_addr;
    logic [crtc_pkg::ADDR_W-1:0]    r_cursor_addr, n_cursor_addr;
    logic [crtc_pkg::REG_IDX_W-1:0] sel_idx;

    assign sel_idx = i_data[crtc_pkg::REG_IDX_W-1:0];

    always_comb begin
        n_sel         = r_sel;
        n_h_total     = r_h_total;
        n_v_total     = r_v_total;
        n_v_adjust    = r_v_adjust;
        n_max_scan    = r_max_scan;
        n_cur_start   = r_cur_start;
        n_cur_end     = r_cur_end;
        n_start_addr  = r_start_addr;
        n_cursor_addr = r_cursor_addr;
        o_read_data   = 8'd0;
        unique case (i_action)
            crtc_pkg::ACT_SELECT: begin
                n_sel = (sel_idx > crtc_pkg::REG_LAST) ? crtc_pkg::REG_INVALID : sel_idx;
            end
            crtc_pkg::ACT_WRITE: begin
                unique case (r_sel)
                    crtc_pkg::REG_H_TOTAL:      n_h_total   = i_data;
                    crtc_pkg::REG_V_TOTAL:      n_v_total   = i_data[6:0];
                    crtc_pkg::REG_V_ADJUST:     n_v_adjust  = i_data[4:0];
                    crtc_pkg::REG_MAX_SCAN:     n_max_scan  = i_data[4:0];
                    crtc_pkg::REG_CURSOR_START: n_cur_start = i_data[6:0];
                    crtc_pkg::REG_CURSOR_END:   n_cur_end   = i_data[4:0];
                    crtc_pkg::REG_START_HI:     n_start_addr  = {i_data[5:0], r_start_addr[7:0]};
                    crtc_pkg::REG_START_LO:     n_start_addr  = {r_start_addr[13:8], i_data};
                    crtc_pkg::REG_CURSOR_HI:    n_cursor_addr = {i_data[5:0], r_cursor_addr[7:0]};
                    crtc_pkg::REG_CURSOR_LO:    n_cursor_addr = {r_cursor_addr[13:8], i_data};
                    default: ;
                endcase
            end
            crtc_pkg::ACT_READ: begin
                priority if (r_sel == crtc_pkg::REG_CURSOR_HI) begin
                    o_read_data = {2'b00, r_cursor_addr[13:8]};
                end else if (r_sel == crtc_pkg::REG_CURSOR_LO) begin
                    o_read_data = r_cursor_addr[7:0];
                end else begin
                    o_read_data = crtc_pkg::READ_NONE;
                end
            end
            crtc_pkg::ACT_TICK: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel         <= crtc_pkg::REG_INVALID;
            r_h_total     <= '0;
            r_v_total     <= '0;
            r_v_adjust    <= '0;
            r_max_scan    <= '0;
            r_cur_start   <= '0;
            r_cur_end     <= '0;
            r_start_addr  <= '0;
            r_cursor_addr <= '0;
        end else if (i_step) begin
            r_sel         <= n_sel;
            r_h_total     <= n_h_total;
            r_v_total     <= n_v_total;
            r_v_adjust    <= n_v_adjust;
            r_max_scan    <= n_max_scan;
            r_cur_start   <= n_cur_start;
            r_cur_end     <= n_cur_end;
            r_start_addr  <= n_start_addr;
            r_cursor_addr <= n_cursor_addr;
        end
    end

    assign o_timing = '{h_total_chars:  r_h_total,
                        v_total_rows:   r_v_total,
                        v_adjust_lines: r_v_adjust,
                        max_scan_line:  r_max_scan};

    // Values after this step, so a write shows up in its own result
    assign o_disp = '{start_addr:   n_start_addr,
                      cursor_addr:  n_cursor_addr,
                      cursor_start: n_cur_start,
                      cursor_end:   n_cur_end};

endmodule

FILE: hw/rtl/crtc_raster.sv
module crtc_raster (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic                            i_tick,
    input  logic [crtc_pkg::CHAR_W_W-1:0]   i_char_width,
    input  crtc_pkg::t_timing               i_timing,
    output crtc_pkg::t_raster               o_status
);

    localparam int unsigned SumW = crtc_pkg::POS_W + 1;

    logic [crtc_pkg::POS_W-1:0]       r_pixel, n_pixel;
    logic [crtc_pkg::POS_W-1:0]       r_line,  n_line;
    logic [crtc_pkg::FRAME_CNT_W-1:0] r_frame, n_frame;
    logic                             r_blink16, n_blink16;
    logic                             r_blink32, n_blink32;

    logic [crtc_pkg::POS_W-1:0] h_total;
    logic [11:0]                v_total;
    logic [SumW-1:0]            h_sum;
    logic [SumW-1:0]            v_inc;
    logic                       row_end;
    logic                       frame_end;
    logic [crtc_pkg::FRAME_CNT_W-1:0] frame_inc;

    assign h_total = 13'(i_timing.h_total_chars) * 13'(i_char_width);
    assign v_total = 12'(i_timing.v_total_rows) * (12'(i_timing.max_scan_line) + 12'd1)
                   + 12'(i_timing.v_adjust_lines);

    assign h_sum     = {1'b0, r_pixel} + SumW'(i_char_width);
    assign row_end   = i_tick && (h_sum >= {1'b0, h_total});
    assign v_inc     = {1'b0, r_line} + SumW'(row_end);
    assign frame_end = i_tick && (v_inc > SumW'(v_total));
    assign frame_inc = r_frame + 1'b1;

    always_comb begin
        n_pixel   = r_pixel;
        n_line    = r_line;
        n_frame   = r_frame;
        n_blink16 = r_blink16;
        n_blink32 = r_blink32;
        if (i_tick) begin
            n_pixel = row_end   ? '0 : h_sum[crtc_pkg::POS_W-1:0];
            n_line  = frame_end ? '0 : v_inc[crtc_pkg::POS_W-1:0];
        end
        if (frame_end) begin
            n_frame   = frame_inc;
            n_blink16 = r_blink16 ^ (frame_inc[3:0] == 4'd0);
            n_blink32 = r_blink32 ^ (frame_inc == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel   <= '0;
            r_line    <= '0;
            r_frame   <= '0;
            r_blink16 <= 1'b0;
            r_blink32 <= 1'b0;
        end else if (i_step) begin
            r_pixel   <= n_pixel;
            r_line    <= n_line;
            r_frame   <= n_frame;
            r_blink16 <= n_blink16;
            r_blink32 <= n_blink32;
        end
    end

    assign o_status = '{row_end:    row_end,
                        frame_end:  frame_end,
                        blink_fast: n_blink16,
                        blink_slow: n_blink32,
                        h_pos:      n_pixel,
                        v_pos:      n_line};

endmodule

FILE: hw/rtl/crt_controller_raster_timing_top.sv
// Channel   | Signals                       | Contents
// ----------+-------------------------------+-------------------------------------------
// s_axis in | i_s_axis_tvalid/tready/tdata  | tdata = data_value; tuser = action
// m_axis out| o_m_axis_tvalid/tready/tdata  | tdata = status fields; tlast = frame_end
// cfg write | i_cfg_wr_en, i_cfg_wr_data    | char_width (5 bits), no read-back
//
// One transaction per cycle sustained while the receiver keeps tready high. Each
// transaction is captured in the input register and resolved into the result
// register when that is empty or being drained, which raises o_m_axis_tvalid.
// Reset is synchronous, active low; char_width returns to 8, the select to invalid.
// A stalled result holds in the output register while the input register still
// takes one more transaction; tready drops only when both are full.
module crt_controller_raster_timing_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] action
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] read_data, [8] row_end, [9] blink_fast, [10] blink_slow,
    // [23:11] h_position, [36:24] v_position, [50:37] display_start,
    // [64:51] cursor_location, [69:65] cursor_first_line,
    // [74:70] cursor_last_line, [76:75] cursor_blink_mode, [79:77] zero
    output logic [79:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,   // frame_end
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data     // char_width
);

    logic [crtc_pkg::CHAR_W_W-1:0] r_char_width;

    // Input register
    logic              r_in_valid;
    crtc_pkg::t_action r_in_action;
    logic [7:0]        r_in_data;

    // Result register
    logic        r_out_valid;
    logic [79:0] r_out_data;
    logic        r_out_last;

    logic adv_out;
    logic s_ready;
    logic step;

    crtc_pkg::t_timing timing;
    crtc_pkg::t_disp   disp;
    crtc_pkg::t_raster status;
    logic [7:0]        read_data;
    logic [79:0]       n_out_data;

    // Advance the result register when it is empty or being drained
    assign adv_out = !r_out_valid || i_m_axis_tready;
    assign s_ready = !r_in_valid || adv_out;
    assign step    = r_in_valid && adv_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_width <= crtc_pkg::CHAR_WIDTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_char_width <= i_cfg_wr_data;
        end
    end

    // Capture the incoming transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_axis_tvalid) begin
            r_in_action <= crtc_pkg::t_action'(i_s_axis_tuser);
            r_in_data   <= i_s_axis_tdata;
        end
    end

    crtc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_action    (r_in_action),
        .i_data      (r_in_data),
        .o_timing    (timing),
        .o_disp      (disp),
        .o_read_data (read_data)
    );

    crtc_raster u_raster (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_tick       (r_in_action == crtc_pkg::ACT_TICK),
        .i_char_width (r_char_width),
        .i_timing     (timing),
        .o_status     (status)
    );

    // Pack the result, highest field first
    assign n_out_data = {3'b000,
                         disp.cursor_start[6:5],
                         disp.cursor_end,
                         disp.cursor_start[4:0],
                         disp.cursor_addr,
                         disp.start_addr,
                         status.v_pos,
                         status.h_pos,
                         status.blink_slow,
                         status.blink_fast,
                         status.row_end,
                         read_data};

    // Result register: load a finished step, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= n_out_data;
            r_out_last <= status.frame_end;
        end
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

FILE: test/tb_crt_controller_raster_timing_top.sv
module tb_crt_controller_raster_timing_top;
    import crtc_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 11;
    // Receiver hold-off used to back the block up until it drops tready
    localparam int SINK_HOLD      = 300;
    // Extra cycles after the last transaction
    localparam int TAIL_CYCLES    = 10;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 240;

    // Indexes that the package leaves unnamed; none of them shows up in a result
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_PEN_HI = 5'd16;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_BAD    = REG_LAST + 5'd1;

    // Everything one result transaction carries, tlast included
    typedef struct packed {
        logic [7:0]        read_data;
        logic              row_end;
        logic              frame_end;
        logic              blink_fast;
        logic              blink_slow;
        logic [POS_W-1:0]  h_pos;
        logic [POS_W-1:0]  v_pos;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] cursor_addr;
        logic [4:0]        cur_first;
        logic [4:0]        cur_last;
        logic [1:0]        cur_mode;
    } crtc_status_t;

    // One row of the directed table; pin < 0 leaves read_data to the predictor
    typedef struct {
        t_action    act;
        logic [7:0] val;
        int         pin;
    } access_row_t;

    logic       clk;
    logic       rst_n;
    logic       s_valid;
    logic [7:0] s_data;
    t_action    s_user;
    int         s_pin;
    logic       m_ready;
    logic       cfg_en;
    logic [4:0] cfg_data;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [79:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    // Predicted CRTC state
    t_timing             timing_m;
    t_disp               disp_m;
    logic [4:0]          sel_m;
    logic [4:0]          char_w_m;
    logic [POS_W-1:0]    pix_m;
    logic [POS_W-1:0]    line_m;
    logic [4:0]          frames_m;
    logic                blink16_m;
    logic                blink32_m;

    crtc_status_t status_q[$];
    access_row_t  access_table[$];
    int           mismatches;
    logic         sender_idle_on;
    logic         sink_idle_on;
    logic         sink_hold_req;

    crt_controller_raster_timing_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_wr_data   (cfg_data)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Idle length: mostly short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Advance the predicted CRTC by one access and return the status it shows
    function automatic crtc_status_t step_crtc(input t_action act, input logic [7:0] val);
        crtc_status_t st;
        int unsigned  h_total;
        int unsigned  v_total;
        int unsigned  h_next;
        int unsigned  v_next;
        st = '0;
        case (act)
            ACT_SELECT: begin
                sel_m = (val[4:0] > REG_LAST) ? REG_INVALID : val[4:0];
            end
            ACT_WRITE: begin
                // Indexes 1..3, 6..8, 16, 17 and invalid feed nothing visible: drop them
                case (sel_m)
                    REG_H_TOTAL:      timing_m.h_total_chars  = val;
                    REG_V_TOTAL:      timing_m.v_total_rows   = val[6:0];
                    REG_V_ADJUST:     timing_m.v_adjust_lines = val[4:0];
                    REG_MAX_SCAN:     timing_m.max_scan_line  = val[4:0];
                    REG_CURSOR_START: disp_m.cursor_start     = val[6:0];
                    REG_CURSOR_END:   disp_m.cursor_end       = val[4:0];
                    REG_START_HI:     disp_m.start_addr[13:8] = val[5:0];
                    REG_START_LO:     disp_m.start_addr[7:0]  = val;
                    REG_CURSOR_HI:    disp_m.cursor_addr[13:8] = val[5:0];
                    REG_CURSOR_LO:    disp_m.cursor_addr[7:0]  = val;
                    default: ;
                endcase
            end
            ACT_READ: begin
                if (sel_m == REG_CURSOR_HI)
                    st.read_data = {2'b00, disp_m.cursor_addr[13:8]};
                else if (sel_m == REG_CURSOR_LO)
                    st.read_data = disp_m.cursor_addr[7:0];
                else
                    st.read_data = READ_NONE;
            end
            default: begin
                // Totals come from the registers as they stand right now
                h_total = timing_m.h_total_chars;
                h_total = h_total * char_w_m;
                v_total = timing_m.max_scan_line;
                v_total = (v_total + 1) * timing_m.v_total_rows + timing_m.v_adjust_lines;
                h_next  = pix_m;
                h_next  = h_next + char_w_m;
                v_next  = line_m;
                if (h_next >= h_total) begin
                    st.row_end = 1'b1;
                    h_next     = 0;
                    v_next     = v_next + 1;
                end
                // Vertical check runs on every tick, not only on line ends
                if (v_next > v_total) begin
                    st.frame_end = 1'b1;
                    frames_m     = frames_m + 5'd1;
                    v_next       = 0;
                    if (frames_m[3:0] == 4'd0) blink16_m = ~blink16_m;
                    if (frames_m == 5'd0) blink32_m = ~blink32_m;
                end
                pix_m  = h_next[POS_W-1:0];
                line_m = v_next[POS_W-1:0];
            end
        endcase
        st.blink_fast  = blink16_m;
        st.blink_slow  = blink32_m;
        st.h_pos       = pix_m;
        st.v_pos       = line_m;
        st.start_addr  = disp_m.start_addr;
        st.cursor_addr = disp_m.cursor_addr;
        st.cur_first   = disp_m.cursor_start[4:0];
        st.cur_last    = disp_m.cursor_end;
        st.cur_mode    = disp_m.cursor_start[6:5];
        return st;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Predict on every accepted input transaction, compare every accepted result
    always @(posedge clk) begin : scoreboard
        crtc_status_t want;
        if (rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                if (status_q.size() == 0) begin
                    $display("%0t: result transaction with nothing expected, actual 0x%0h",
                             $time, o_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = status_q.pop_front();
                    check_field("read_data",  want.read_data,   o_m_axis_tdata[7:0]);
                    check_field("row_end",    want.row_end,     o_m_axis_tdata[8]);
                    check_field("frame_end",  want.frame_end,   o_m_axis_tlast);
                    check_field("blink_fast", want.blink_fast,  o_m_axis_tdata[9]);
                    check_field("blink_slow", want.blink_slow,  o_m_axis_tdata[10]);
                    check_field("h_position", want.h_pos,       o_m_axis_tdata[23:11]);
                    check_field("v_position", want.v_pos,       o_m_axis_tdata[36:24]);
                    check_field("display_start", want.start_addr, o_m_axis_tdata[50:37]);
                    check_field("cursor_location", want.cursor_addr, o_m_axis_tdata[64:51]);
                    check_field("cursor_first_line", want.cur_first, o_m_axis_tdata[69:65]);
                    check_field("cursor_last_line", want.cur_last, o_m_axis_tdata[74:70]);
                    check_field("cursor_blink_mode", want.cur_mode, o_m_axis_tdata[76:75]);
                    check_field("pad", 16'd0, o_m_axis_tdata[79:77]);
                end
            end
            if (s_valid && o_s_axis_tready) begin
                want = step_crtc(s_user, s_data);
                // A pinned row overrides the predicted byte with the typed-in one
                if (s_pin >= 0) want.read_data = s_pin[7:0];
                status_q.push_back(want);
            end
            if (cfg_en) char_w_m = cfg_data;
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here on request
    initial begin : sink
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (sink_hold_req) begin
                m_ready = 1'b0;
                repeat (SINK_HOLD) @(negedge clk);
                sink_hold_req = 1'b0;
                m_ready       = 1'b1;
            end else if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else if (sink_idle_on && $urandom_range(0, 99) < 25) begin
                m_ready = 1'b0;
                stall   = gap_len() - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Offer one transaction at the falling edge and hold it until accepted.
    // Valid stays up on return so back-to-back transactions need no gap.
    task automatic send_item(input t_action act, input logic [7:0] val, input int pin);
        if (sender_idle_on && $urandom_range(0, 99) < 30) begin
            s_valid = 1'b0;
            repeat (gap_len()) @(negedge clk);
        end
        s_user  = act;
        s_data  = val;
        s_pin   = pin;
        s_valid = 1'b1;
        @(posedge clk);
        while (!o_s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic drain();
        s_valid = 1'b0;
        while (status_q.size() != 0) @(negedge clk);
    endtask

    task automatic add_row(input t_action act, input logic [7:0] val, input int pin);
        access_row_t row;
        row.act = act;
        row.val = val;
        row.pin = pin;
        access_table.push_back(row);
    endtask

    // Value for a register write; timing registers stay small most of the
    // time so that lines and frames wrap often
    function automatic logic [7:0] reg_value(input logic [REG_IDX_W-1:0] idx);
        if ($urandom_range(0, 99) < 15) return 8'($urandom);
        case (idx)
            REG_H_TOTAL:  return 8'($urandom_range(0, 6));
            REG_V_TOTAL,
            REG_V_ADJUST,
            REG_MAX_SCAN: return 8'($urandom_range(0, 3));
            default:      return 8'($urandom);
        endcase
    endfunction

    function automatic logic [REG_IDX_W-1:0] pick_reg();
        case ($urandom_range(0, 9))
            0:       return REG_H_TOTAL;
            1:       return REG_V_TOTAL;
            2:       return REG_V_ADJUST;
            3:       return REG_MAX_SCAN;
            4:       return REG_CURSOR_START;
            5:       return REG_CURSOR_END;
            6:       return REG_START_HI;
            7:       return REG_START_LO;
            8:       return REG_CURSOR_HI;
            default: return REG_CURSOR_LO;
        endcase
    endfunction

    // Mostly select/write and select/read pairs and tick bursts, some noise
    task automatic random_phase(input int n_items);
        int                   sent;
        int                   r;
        int                   burst;
        logic [REG_IDX_W-1:0] idx;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                idx = ($urandom_range(0, 9) == 0) ? 5'($urandom) : pick_reg();
                send_item(ACT_SELECT, {3'($urandom), idx}, -1);
                send_item(ACT_WRITE, reg_value(idx), -1);
                sent += 2;
            end else if (r < 52) begin
                case ($urandom_range(0, 2))
                    0:       idx = REG_CURSOR_HI;
                    1:       idx = REG_CURSOR_LO;
                    default: idx = 5'($urandom);
                endcase
                send_item(ACT_SELECT, {3'($urandom), idx}, -1);
                send_item(ACT_READ, 8'($urandom), -1);
                sent += 2;
            end else if (r < 90) begin
                burst = $urandom_range(1, 16);
                repeat (burst) send_item(ACT_TICK, 8'($urandom), -1);
                sent += burst;
            end else begin
                send_item(t_action'($urandom_range(0, 3)), 8'($urandom), -1);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        logic [4:0] width;
        // Known values on every input from time zero
        rst_n          = 1'b0;
        s_valid        = 1'b0;
        s_data         = 8'd0;
        s_user         = ACT_SELECT;
        s_pin          = -1;
        cfg_en         = 1'b0;
        cfg_data       = 5'd0;
        sender_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        sink_hold_req  = 1'b0;
        mismatches     = 0;

        // Predicted state after reset
        timing_m  = '0;
        disp_m    = '0;
        sel_m     = REG_INVALID;
        char_w_m  = CHAR_WIDTH_RESET;
        pix_m     = '0;
        line_m    = '0;
        frames_m  = '0;
        blink16_m = 1'b0;
        blink32_m = 1'b0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed table: reset state, masking, invalid and ignored
        // registers, cursor byte reads, extreme write values, first ticks
        add_row(ACT_READ,   8'h00, READ_NONE);          // select is invalid out of reset
        add_row(ACT_TICK,   8'h00, -1);                 // zero totals: line and frame end
        add_row(ACT_SELECT, 8'hFF, -1);                 // masks to 31, stays invalid
        add_row(ACT_READ,   8'h00, READ_NONE);
        add_row(ACT_SELECT, {3'b000, REG_CURSOR_HI}, -1);
        add_row(ACT_WRITE,  8'hFF, -1);                 // only six bits kept
        add_row(ACT_READ,   8'h00, 8'h3F);
        add_row(ACT_SELECT, {3'b000, REG_CURSOR_LO}, -1);
        add_row(ACT_WRITE,  8'hA5, -1);
        add_row(ACT_READ,   8'h00, 8'hA5);
        add_row(ACT_SELECT, {3'b000, REG_FIRST_BAD}, -1); // just past the last index
        add_row(ACT_WRITE,  8'h55, -1);                 // ignored
        add_row(ACT_READ,   8'h00, READ_NONE);
        add_row(ACT_SELECT, {3'b000, REG_LIGHT_PEN_HI}, -1);
        add_row(ACT_WRITE,  8'h12, -1);                 // read-only slot, ignored
        add_row(ACT_READ,   8'h00, READ_NONE);
        add_row(ACT_SELECT, {3'b000, REG_CURSOR_START}, -1);
        add_row(ACT_WRITE,  8'hFF, -1);
        add_row(ACT_SELECT, {3'b000, REG_CURSOR_END}, -1);
        add_row(ACT_WRITE,  8'hFF, -1);
        add_row(ACT_SELECT, {3'b000, REG_START_HI}, -1);
        add_row(ACT_WRITE,  8'hFF, -1);
        add_row(ACT_SELECT, {3'b000, REG_H_TOTAL}, -1);
        add_row(ACT_WRITE,  8'h02, -1);
        add_row(ACT_TICK,   8'hFF, -1);
        foreach (access_table[i])
            send_item(access_table[i].act, access_table[i].val, access_table[i].pin);

        // Random phases; each starts from an idle block with a new char width
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0:       width = CHAR_WIDTH_RESET;
                1:       width = 5'd0;      // horizontal position never advances
                2:       width = 5'd31;
                3:       width = 5'd1;
                4:       width = 5'd16;
                6:       width = 5'd3;
                default: width = 5'($urandom);
            endcase
            cfg_data = width;
            cfg_en   = 1'b1;
            @(negedge clk);
            cfg_en   = 1'b0;

            // Phase 3 runs at full rate on both sides; phase 6 stalls only the sender
            sender_idle_on = (p != 3);
            sink_idle_on   = (p != 3) && (p != 6);
            // Phase 2 backs the block up against a receiver that holds off
            if (p == 2) sink_hold_req = 1'b1;
            random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/crtc_pkg.sv
hw/rtl/crtc_regs.sv
hw/rtl/crtc_raster.sv
hw/rtl/crt_controller_raster_timing_top.sv
test/tb_crt_controller_raster_timing_top.sv
